// ===== sv/trgb_pkg.sv =====
// ----------------------------------------------------------------------------
// trgb_pkg: shared types and constants of the tiled RGB5A3 decoder
// Image geometry, field widths, register indexes and the structs that carry
// decoded tile rows and finished pixels between the front and back parts.
// ----------------------------------------------------------------------------
package trgb_pkg;

    // Image geometry in texels and the largest replication factor.
    localparam int IMAGE_WIDTH  = 192;
    localparam int IMAGE_HEIGHT = 64;
    localparam int MAX_SCALE    = 4;

    // Partial tiles are dropped, so the image is counted in whole tiles.
    localparam int TILES_ACROSS = IMAGE_WIDTH / 4;
    localparam int TILES_DOWN   = IMAGE_HEIGHT / 4;
    localparam int TC_W = (TILES_ACROSS > 1) ? $clog2(TILES_ACROSS) : 1;
    localparam int TR_W = (TILES_DOWN > 1) ? $clog2(TILES_DOWN) : 1;

    // Texels per tile row and the index width that selects one of them.
    localparam int TEXELS  = 4;
    localparam int K_W     = 2;

    // Field widths fixed by the interface.
    localparam int TEXEL_W  = 16;
    localparam int ORIGIN_W = 11;
    localparam int SCALE_W  = 3;
    localparam int PIX_W    = 12;
    localparam int CHAN_W   = 8;
    localparam int CFG_W    = ORIGIN_W;
    localparam int CFG_IDX_W = 2;

    // Replication counters run from 0 to MAX_SCALE-1.
    localparam int SCNT_W = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

    // Depth of the queue between the front and the back part.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 2'd2;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } color_t;

    // One classified tile row, as the back part needs it.
    typedef struct packed {
        logic [PIX_W-1:0]       base_x;
        logic [PIX_W-1:0]       base_y;
        logic [SCALE_W-1:0]     scale;
        logic                   image_end;
        color_t [TEXELS-1:0]    colors;
    } entry_t;

    // Handshake status of the queue as seen by its two neighbors.
    typedef struct packed {
        logic full;
        logic valid;
    } q_stat_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
        color_t           color;
        logic             last_of_item;
        logic             last_of_image;
    } pixel_t;

endpackage

// ===== sv/trgb_front.sv =====
// ----------------------------------------------------------------------------
// trgb_front: accepts tile rows and classifies them
// Holds the configuration registers and the tile position, decodes the four
// texels and computes the screen base of the row for the back part.
// ----------------------------------------------------------------------------
module trgb_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [trgb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [trgb_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            accept,
    input  logic [trgb_pkg::TEXEL_W-1:0]    texel_0,
    input  logic [trgb_pkg::TEXEL_W-1:0]    texel_1,
    input  logic [trgb_pkg::TEXEL_W-1:0]    texel_2,
    input  logic [trgb_pkg::TEXEL_W-1:0]    texel_3,
    output trgb_pkg::entry_t                entry
);
    import trgb_pkg::*;

    logic [ORIGIN_W-1:0] origin_x_reg;
    logic [ORIGIN_W-1:0] origin_y_reg;
    logic [SCALE_W-1:0]  scale_factor_reg;
    logic [TC_W-1:0]     tile_column_reg, tile_column_next;
    logic [TR_W-1:0]     tile_row_reg, tile_row_next;
    logic [1:0]          row_in_tile_reg, row_in_tile_next;

    logic [SCALE_W-1:0]  eff_scale;
    logic                last_column;
    logic                last_row;

    // Bit 15 selects the opaque 5-5-5 form or the translucent 3-4-4-4 form.
    function automatic color_t decode_texel(input logic [TEXEL_W-1:0] v);
        color_t c;
        if (v[15])
        begin
            c.red   = {v[14:10], 3'b000};
            c.green = {v[9:5], 3'b000};
            c.blue  = {v[4:0], 3'b000};
            c.alpha = 8'hFF;
        end
        else
        begin
            c.red   = {v[11:8], v[11:8]};
            c.green = {v[7:4], v[7:4]};
            c.blue  = {v[3:0], v[3:0]};
            c.alpha = {v[14:12], 5'b00000} + {3'b000, v[14:12], 2'b00};
        end
        return c;
    endfunction

    always_comb
    begin
        if (scale_factor_reg == '0)
            eff_scale = SCALE_W'(1);
        else if (scale_factor_reg > SCALE_W'(MAX_SCALE))
            eff_scale = SCALE_W'(MAX_SCALE);
        else
            eff_scale = scale_factor_reg;
    end

    assign last_column = (tile_column_reg == TC_W'(TILES_ACROSS - 1));
    assign last_row    = (tile_row_reg == TR_W'(TILES_DOWN - 1));

    always_comb
    begin
        entry.base_x = PIX_W'(origin_x_reg)
                     + PIX_W'({tile_column_reg, 2'b00}) * PIX_W'(eff_scale);
        entry.base_y = PIX_W'(origin_y_reg)
                     + PIX_W'({tile_row_reg, row_in_tile_reg}) * PIX_W'(eff_scale);
        entry.scale     = eff_scale;
        entry.image_end = last_column && last_row && (row_in_tile_reg == 2'd3);
        entry.colors[0] = decode_texel(texel_0);
        entry.colors[1] = decode_texel(texel_1);
        entry.colors[2] = decode_texel(texel_2);
        entry.colors[3] = decode_texel(texel_3);
    end

    always_comb
    begin
        row_in_tile_next = row_in_tile_reg + 2'd1;
        tile_column_next = tile_column_reg;
        tile_row_next    = tile_row_reg;
        if (row_in_tile_reg == 2'd3)
        begin
            if (last_column)
            begin
                tile_column_next = '0;
                tile_row_next    = last_row ? '0 : tile_row_reg + TR_W'(1);
            end
            else
            begin
                tile_column_next = tile_column_reg + TC_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            scale_factor_reg <= SCALE_W'(1);
            tile_column_reg  <= '0;
            tile_row_reg     <= '0;
            row_in_tile_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ORIGIN_X:     origin_x_reg     <= cfg_data;
                    REG_ORIGIN_Y:     origin_y_reg     <= cfg_data;
                    REG_SCALE_FACTOR: scale_factor_reg <= cfg_data[SCALE_W-1:0];
                    default:          ;
                endcase
            end
            if (accept)
            begin
                tile_column_reg <= tile_column_next;
                tile_row_reg    <= tile_row_next;
                row_in_tile_reg <= row_in_tile_next;
            end
        end
    end

endmodule

// ===== sv/trgb_queue.sv =====
// ----------------------------------------------------------------------------
// trgb_queue: short queue of classified tile rows
// Decouples the front part from the back part so that each can stall alone.
// ----------------------------------------------------------------------------
module trgb_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  trgb_pkg::entry_t   wr_data,
    input  logic               pop,
    output trgb_pkg::entry_t   rd_data,
    output trgb_pkg::q_stat_t  stat
);
    import trgb_pkg::*;

    entry_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.valid = (count_reg != '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && stat.valid;
    assign rd_data    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + QPTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== sv/trgb_back.sv =====
// ----------------------------------------------------------------------------
// trgb_back: replicates a tile row into screen pixels
// Walks the scale block row by row into an output register that the result
// side drains, one pixel per cycle while that side keeps popping.
// ----------------------------------------------------------------------------
module trgb_back (
    input  logic               clk,
    input  logic               rst_n,
    input  trgb_pkg::entry_t   q_data,
    input  logic               q_valid,
    output logic               q_pop,
    input  logic               pop,
    output logic               empty,
    output trgb_pkg::pixel_t   pixel
);
    import trgb_pkg::*;

    logic                active_reg;
    entry_t              ent_reg;
    logic [SCNT_W-1:0]   dx_reg;
    logic [SCNT_W-1:0]   dy_reg;
    logic [K_W-1:0]      k_reg;
    logic [PIX_W-1:0]    x_reg;
    logic [PIX_W-1:0]    y_reg;
    logic                out_valid_reg;
    pixel_t              pixel_reg;

    logic                advance;
    logic                dx_end;
    logic                dy_end;
    logic                k_end;
    logic                last_px;
    logic                load;

    assign advance = active_reg && (!out_valid_reg || pop);
    assign dx_end  = (SCALE_W'(dx_reg) == ent_reg.scale - SCALE_W'(1));
    assign dy_end  = (SCALE_W'(dy_reg) == ent_reg.scale - SCALE_W'(1));
    assign k_end   = (k_reg == K_W'(TEXELS - 1));
    assign last_px = dx_end && dy_end && k_end;
    // The next row is taken in the same cycle as the last pixel of this one.
    assign load    = q_valid && (!active_reg || (advance && last_px));
    assign q_pop   = load;
    assign empty   = !out_valid_reg;
    assign pixel   = pixel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            k_reg         <= '0;
        end
        else
        begin
            if (advance)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;

            if (load)
            begin
                active_reg <= 1'b1;
                dx_reg     <= '0;
                dy_reg     <= '0;
                k_reg      <= '0;
            end
            else if (advance)
            begin
                if (last_px)
                    active_reg <= 1'b0;
                if (dx_end)
                begin
                    dx_reg <= '0;
                    if (k_end)
                    begin
                        k_reg  <= '0;
                        dy_reg <= dy_reg + SCNT_W'(1);
                    end
                    else
                    begin
                        k_reg <= k_reg + K_W'(1);
                    end
                end
                else
                begin
                    dx_reg <= dx_reg + SCNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pixel_reg.pixel_x       <= x_reg;
            pixel_reg.pixel_y       <= y_reg;
            pixel_reg.color         <= ent_reg.colors[k_reg];
            pixel_reg.last_of_item  <= last_px;
            pixel_reg.last_of_image <= last_px && ent_reg.image_end;
        end
        if (load)
        begin
            ent_reg <= q_data;
            x_reg   <= q_data.base_x;
            y_reg   <= q_data.base_y;
        end
        else if (advance)
        begin
            // Pixels of one screen row are contiguous across the four texels.
            if (dx_end && k_end)
            begin
                x_reg <= ent_reg.base_x;
                y_reg <= y_reg + PIX_W'(1);
            end
            else
            begin
                x_reg <= x_reg + PIX_W'(1);
            end
        end
    end

endmodule

// ===== sv/tiled_rgb5a3_texel_decode_scale.sv =====
// ----------------------------------------------------------------------------
// tiled_rgb5a3_texel_decode_scale: tiled RGB5A3 decoder with integer scaling
// Path: queue slot, then the back's row register, then the output register.
// Throughput: one pixel per cycle while the result side keeps popping, so a
// tile row of effective scale s yields 4*s*s pixels walked by the back.
// Reset: rst_n clears the tile position, queue and output register at once;
// origin registers return to zero and the scale factor to one.
// ----------------------------------------------------------------------------
module tiled_rgb5a3_texel_decode_scale (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write port.
    input  logic                            cfg_we,
    input  logic [trgb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [trgb_pkg::CFG_W-1:0]      cfg_data,
    // Input side: one tile row per transaction.
    input  logic                            push,
    output logic                            full,
    input  logic [trgb_pkg::TEXEL_W-1:0]    texel_0,
    input  logic [trgb_pkg::TEXEL_W-1:0]    texel_1,
    input  logic [trgb_pkg::TEXEL_W-1:0]    texel_2,
    input  logic [trgb_pkg::TEXEL_W-1:0]    texel_3,
    // Result side: one screen pixel per transaction.
    output logic                            empty,
    input  logic                            pop,
    output logic [trgb_pkg::PIX_W-1:0]      pixel_x,
    output logic [trgb_pkg::PIX_W-1:0]      pixel_y,
    output logic [trgb_pkg::CHAN_W-1:0]     red,
    output logic [trgb_pkg::CHAN_W-1:0]     green,
    output logic [trgb_pkg::CHAN_W-1:0]     blue,
    output logic [trgb_pkg::CHAN_W-1:0]     alpha,
    output logic                            last_of_item,
    output logic                            last_of_image
);
    import trgb_pkg::*;

    // The front decodes the texels and fixes the screen base of the row at
    // the moment it is accepted, so the scale and origin in force then are
    // the ones the row keeps all the way through the back part.
    entry_t   front_entry;
    entry_t   head_entry;
    q_stat_t  q_stat;
    logic     accept;
    logic     q_pop;
    pixel_t   pixel;

    // An input transaction completes whenever the queue has room; the queue
    // keeps taking rows while the back is still replicating older ones.
    assign full   = q_stat.full;
    assign accept = push && !q_stat.full;

    trgb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .texel_0   (texel_0),
        .texel_1   (texel_1),
        .texel_2   (texel_2),
        .texel_3   (texel_3),
        .entry     (front_entry)
    );

    trgb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (accept),
        .wr_data (front_entry),
        .pop     (q_pop),
        .rd_data (head_entry),
        .stat    (q_stat)
    );

    // The back walks each row's scale block into an output register; a waiting
    // result stalls the walk, and the input side only once the queue is full.
    trgb_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (head_entry),
        .q_valid (q_stat.valid),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .pixel   (pixel)
    );

    assign pixel_x       = pixel.pixel_x;
    assign pixel_y       = pixel.pixel_y;
    assign red           = pixel.color.red;
    assign green         = pixel.color.green;
    assign blue          = pixel.color.blue;
    assign alpha         = pixel.color.alpha;
    assign last_of_item  = pixel.last_of_item;
    assign last_of_image = pixel.last_of_image;

endmodule

// ===== tb/tiled_rgb5a3_checker.sv =====
// ----------------------------------------------------------------------------
// tiled_rgb5a3_checker: pixel predictor and comparator for the tile decoder
// Watches the register port and both queue sides of the decoder. Every tile
// row that goes in is turned into its expected screen pixels, and every pixel
// that comes out is compared field by field with the oldest one waiting.
// ----------------------------------------------------------------------------
module tiled_rgb5a3_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [trgb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [trgb_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           push,
    input  logic                           full,
    input  logic [trgb_pkg::TEXEL_W-1:0]   texel_0,
    input  logic [trgb_pkg::TEXEL_W-1:0]   texel_1,
    input  logic [trgb_pkg::TEXEL_W-1:0]   texel_2,
    input  logic [trgb_pkg::TEXEL_W-1:0]   texel_3,
    input  logic                           empty,
    input  logic                           pop,
    input  logic [trgb_pkg::PIX_W-1:0]     pixel_x,
    input  logic [trgb_pkg::PIX_W-1:0]     pixel_y,
    input  logic [trgb_pkg::CHAN_W-1:0]    red,
    input  logic [trgb_pkg::CHAN_W-1:0]    green,
    input  logic [trgb_pkg::CHAN_W-1:0]    blue,
    input  logic [trgb_pkg::CHAN_W-1:0]    alpha,
    input  logic                           last_of_item,
    input  logic                           last_of_image,
    output int                             mismatches,
    output int                             pixels_pending
);
    import trgb_pkg::*;

    // A 4-bit channel widens to 8 bits by times 17, a 3-bit alpha by times 36.
    localparam int NIBBLE_SCALE  = 17;
    localparam int ALPHA_STEP    = 36;
    localparam int ROWS_PER_TILE = 4;

    logic [ORIGIN_W-1:0] origin_x_q;
    logic [ORIGIN_W-1:0] origin_y_q;
    logic [SCALE_W-1:0]  scale_q;
    logic [TC_W-1:0]     tile_col;
    logic [TR_W-1:0]     tile_row;
    logic [1:0]          row_in_tile;

    pixel_t expected_pixels[$];

    function automatic color_t decode_rgb5a3(input logic [TEXEL_W-1:0] t);
        color_t c;
        if (t[15]) begin
            c.red   = {t[14:10], 3'b000};
            c.green = {t[9:5], 3'b000};
            c.blue  = {t[4:0], 3'b000};
            c.alpha = '1;
        end
        else begin
            c.red   = CHAN_W'(t[11:8] * NIBBLE_SCALE);
            c.green = CHAN_W'(t[7:4] * NIBBLE_SCALE);
            c.blue  = CHAN_W'(t[3:0] * NIBBLE_SCALE);
            c.alpha = CHAN_W'(t[14:12] * ALPHA_STEP);
        end
        return c;
    endfunction

    // Zero acts as one and anything above the largest factor is clamped.
    function automatic int effective_scale();
        int s;
        s = int'(scale_q);
        if (s == 0)
            s = 1;
        else if (s > MAX_SCALE)
            s = MAX_SCALE;
        return s;
    endfunction

    task automatic predict_tile_row(input logic [TEXEL_W-1:0] t0, t1, t2, t3);
        color_t colors [TEXELS];
        pixel_t p;
        int     s;
        int     total;
        int     n;
        int     base_x;
        int     base_y;
        bit     image_end;
        colors[0] = decode_rgb5a3(t0);
        colors[1] = decode_rgb5a3(t1);
        colors[2] = decode_rgb5a3(t2);
        colors[3] = decode_rgb5a3(t3);
        s         = effective_scale();
        total     = TEXELS * s * s;
        n         = 0;
        image_end = (int'(tile_col) == TILES_ACROSS - 1) && (int'(tile_row) == TILES_DOWN - 1)
                    && (int'(row_in_tile) == ROWS_PER_TILE - 1);
        base_x    = int'(origin_x_q) + int'(tile_col) * TEXELS * s;
        base_y    = int'(origin_y_q) + (int'(tile_row) * ROWS_PER_TILE + int'(row_in_tile)) * s;
        // Pixels leave row by row, each texel repeated s times across.
        for (int dy = 0; dy < s; dy++) begin
            for (int k = 0; k < TEXELS; k++) begin
                for (int dx = 0; dx < s; dx++) begin
                    n++;
                    p.pixel_x       = PIX_W'(base_x + k * s + dx);
                    p.pixel_y       = PIX_W'(base_y + dy);
                    p.color         = colors[k];
                    p.last_of_item  = (n == total);
                    p.last_of_image = (n == total) && image_end;
                    expected_pixels.push_back(p);
                end
            end
        end
        if (int'(row_in_tile) == ROWS_PER_TILE - 1) begin
            row_in_tile = '0;
            if (int'(tile_col) == TILES_ACROSS - 1) begin
                tile_col = '0;
                if (int'(tile_row) == TILES_DOWN - 1)
                    tile_row = '0;
                else
                    tile_row = tile_row + TR_W'(1);
            end
            else begin
                tile_col = tile_col + TC_W'(1);
            end
        end
        else begin
            row_in_tile = row_in_tile + 2'd1;
        end
    endtask

    task automatic compare_field(input string name, input logic [PIX_W-1:0] want, got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_pixel();
        pixel_t want;
        if (expected_pixels.size() == 0) begin
            $error("pixel at (%0d,%0d) arrived with no tile row waiting", pixel_x, pixel_y);
            mismatches++;
        end
        else begin
            want = expected_pixels.pop_front();
            compare_field("pixel_x", want.pixel_x, pixel_x);
            compare_field("pixel_y", want.pixel_y, pixel_y);
            compare_field("red", PIX_W'(want.color.red), PIX_W'(red));
            compare_field("green", PIX_W'(want.color.green), PIX_W'(green));
            compare_field("blue", PIX_W'(want.color.blue), PIX_W'(blue));
            compare_field("alpha", PIX_W'(want.color.alpha), PIX_W'(alpha));
            compare_field("last_of_item", PIX_W'(want.last_of_item), PIX_W'(last_of_item));
            compare_field("last_of_image", PIX_W'(want.last_of_image),
                          PIX_W'(last_of_image));
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            origin_x_q  = '0;
            origin_y_q  = '0;
            scale_q     = SCALE_W'(1);
            tile_col    = '0;
            tile_row    = '0;
            row_in_tile = '0;
            expected_pixels.delete();
            pixels_pending = 0;
        end
        else begin
            if (pop && !empty)
                check_pixel();
            if (cfg_we) begin
                case (cfg_index)
                    REG_ORIGIN_X:     origin_x_q = cfg_data[ORIGIN_W-1:0];
                    REG_ORIGIN_Y:     origin_y_q = cfg_data[ORIGIN_W-1:0];
                    REG_SCALE_FACTOR: scale_q    = cfg_data[SCALE_W-1:0];
                    default:          ;
                endcase
            end
            if (push && !full)
                predict_tile_row(texel_0, texel_1, texel_2, texel_3);
            pixels_pending = expected_pixels.size();
        end
    end

endmodule

// ===== tb/tb_tiled_rgb5a3_texel_decode_scale.sv =====
// ----------------------------------------------------------------------------
// tb_tiled_rgb5a3_texel_decode_scale: self-checking bench for the decoder
// Feeds directed and random tile rows through the decoder under changing
// origins and scale factors, throttles both queue sides at random, and leaves
// all checking to the pixel checker.
// ----------------------------------------------------------------------------
module tb_tiled_rgb5a3_texel_decode_scale;

    import trgb_pkg::*;

    // Index 3 is not a register; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int RANDOM_ROWS    = 350;
    // A short tail after the last expected pixel is enough to catch any stray
    // pixel that follows it.
    localparam int DRAIN_CYCLES   = 20;
    // A correct run never goes this long without a transaction on either side:
    // the longest random stall at 71 percent idling stays far below this limit.
    localparam int WATCHDOG_LIMIT = 5000;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [CFG_W-1:0]     cfg_data      = '0;
    logic                 push          = 1'b0;
    logic                 full;
    logic [TEXEL_W-1:0]   texel_0       = '0;
    logic [TEXEL_W-1:0]   texel_1       = '0;
    logic [TEXEL_W-1:0]   texel_2       = '0;
    logic [TEXEL_W-1:0]   texel_3       = '0;
    logic                 empty;
    logic                 pop           = 1'b0;
    logic [PIX_W-1:0]     pixel_x;
    logic [PIX_W-1:0]     pixel_y;
    logic [CHAN_W-1:0]    red;
    logic [CHAN_W-1:0]    green;
    logic [CHAN_W-1:0]    blue;
    logic [CHAN_W-1:0]    alpha;
    logic                 last_of_item;
    logic                 last_of_image;

    int pixel_mismatches;
    int pixels_pending;

    // Percent of cycles in which the row source holds back and the pixel sink stalls.
    int send_idle_pct = 22;
    int recv_idle_pct = 71;

    int rows_sent    = 0;
    int pixels_seen  = 0;
    int settings     = 0;
    int idle_cycles  = 0;

    tiled_rgb5a3_texel_decode_scale dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .texel_0       (texel_0),
        .texel_1       (texel_1),
        .texel_2       (texel_2),
        .texel_3       (texel_3),
        .empty         (empty),
        .pop           (pop),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .alpha         (alpha),
        .last_of_item  (last_of_item),
        .last_of_image (last_of_image)
    );

    tiled_rgb5a3_checker pixel_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .texel_0        (texel_0),
        .texel_1        (texel_1),
        .texel_2        (texel_2),
        .texel_3        (texel_3),
        .empty          (empty),
        .pop            (pop),
        .pixel_x        (pixel_x),
        .pixel_y        (pixel_y),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .alpha          (alpha),
        .last_of_item   (last_of_item),
        .last_of_image  (last_of_image),
        .mismatches     (pixel_mismatches),
        .pixels_pending (pixels_pending)
    );

    always #5 clk = ~clk;

    // The pixel sink decides afresh on every cycle whether to take a pixel.
    always @(negedge clk) begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    // The watchdog restarts on every transaction and ends a run that has hung.
    always @(posedge clk) begin
        if (rst_n) begin
            if (pop && !empty)
                pixels_seen++;
            if ((push && !full) || (pop && !empty)) begin
                idle_cycles = 0;
            end
            else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("Watchdog expired after %0d cycles without a transaction",
                             idle_cycles);
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    // Every task below starts and ends at a falling edge, where all inputs change.

    // Offers one tile row, idling first at random, and returns once it is taken.
    task automatic send_tile_row(input logic [TEXEL_W-1:0] t0, t1, t2, t3);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push    <= 1'b1;
        texel_0 <= t0;
        texel_1 <= t1;
        texel_2 <= t2;
        texel_3 <= t3;
        @(posedge clk);
        while (full)
            @(posedge clk);
        rows_sent++;
        @(negedge clk);
    endtask

    task automatic send_random_row();
        send_tile_row(TEXEL_W'($urandom), TEXEL_W'($urandom), TEXEL_W'($urandom),
                      TEXEL_W'($urandom));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    // Registers change only with the decoder empty: no row held back and every
    // predicted pixel already taken. The scale word may carry junk above bit 2.
    task automatic configure(input logic [CFG_W-1:0] ox, oy, scale_word,
                             input bit poke_unused);
        push <= 1'b0;
        while (pixels_pending != 0)
            @(negedge clk);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_SCALE_FACTOR, scale_word);
        if (poke_unused)
            write_reg(REG_UNUSED, CFG_W'($urandom_range(2047)));
        cfg_we <= 1'b0;
        settings++;
    endtask

    function automatic logic [CFG_W-1:0] random_origin();
        int pick;
        pick = $urandom_range(9);
        if (pick < 2)
            return '0;
        else if (pick < 4)
            return '1;
        return CFG_W'($urandom_range(2047));
    endfunction

    // Mostly small factors keep the run short; the out-of-range codes still show up.
    function automatic logic [CFG_W-1:0] random_scale_word();
        logic [CFG_W-1:0] word;
        int               pick;
        word = CFG_W'($urandom_range(2047));
        pick = $urandom_range(99);
        if (pick < 35)
            word[SCALE_W-1:0] = 3'd1;
        else if (pick < 60)
            word[SCALE_W-1:0] = 3'd2;
        else if (pick < 70)
            word[SCALE_W-1:0] = 3'd0;
        else if (pick < 80)
            word[SCALE_W-1:0] = 3'd3;
        else if (pick < 88)
            word[SCALE_W-1:0] = 3'd4;
        else
            word[SCALE_W-1:0] = SCALE_W'($urandom_range(7, 5));
        return word;
    endfunction

    initial begin
        int seg;
        int left;
        int len;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed rows. The first four run on the reset values of the registers
        // and hit the channel extremes of both texel forms: transparent black,
        // opaque white, each opaque channel alone, each nibble alone, alpha alone.
        send_tile_row(16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF);
        send_tile_row(16'hFC00, 16'h83E0, 16'h801F, 16'h7000);
        send_tile_row(16'h0F00, 16'h00F0, 16'h000F, 16'h1234);
        send_tile_row(16'hAAAA, 16'h5555, 16'hCCCC, 16'h3333);
        // Largest origins with a scale code of zero, which acts as one.
        configure(11'h7FF, 11'h7FF, 11'h7F8, 1'b0);
        repeat (2) send_random_row();
        // A code of seven clamps to the largest factor; the unused index is poked.
        configure(11'h7FF, 11'h000, 11'h007, 1'b1);
        repeat (2) send_random_row();
        configure(11'h000, 11'h7FF, 11'h004, 1'b0);
        repeat (2) send_random_row();
        configure(11'h400, 11'h3FF, 11'h005, 1'b0);
        send_random_row();
        configure(11'h000, 11'h000, 11'h003, 1'b0);
        repeat (2) send_random_row();
        configure(11'h005, 11'h009, 11'h002, 1'b0);
        repeat (2) send_random_row();
        configure(11'h7FF, 11'h7FF, 11'h006, 1'b1);
        send_random_row();
        configure(11'h000, 11'h000, 11'h001, 1'b0);
        repeat (4) send_random_row();

        // Random rows in three stretches: sink mostly stalled, source mostly
        // idle, then no idling at all. Each stretch is cut into settings phases,
        // so the scale also changes partway through tiles.
        for (seg = 0; seg < 3; seg++) begin
            case (seg)
                0: begin
                    send_idle_pct = 22;
                    recv_idle_pct = 71;
                end
                1: begin
                    send_idle_pct = 71;
                    recv_idle_pct = 22;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            left = RANDOM_ROWS / 3;
            while (left > 0) begin
                len = $urandom_range(40, 10);
                if (len > left)
                    len = left;
                configure(random_origin(), random_origin(), random_scale_word(),
                          $urandom_range(3) == 0);
                repeat (len) send_random_row();
                left -= len;
            end
        end

        push <= 1'b0;
        while (pixels_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d tile rows under %0d register settings, %0d pixels checked,",
                 rows_sent, settings, pixels_seen);
        $display("with both queue sides throttled in turn and then running free.");
        if (pixel_mismatches == 0 && pixels_pending == 0) begin
            $display("SUCCESS");
        end
        else begin
            $display("%0d mismatches, %0d pixels never arrived",
                     pixel_mismatches, pixels_pending);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== tiled_rgb5a3_texel_decode_scale.f =====
sv/trgb_pkg.sv
sv/trgb_front.sv
sv/trgb_queue.sv
sv/trgb_back.sv
sv/tiled_rgb5a3_texel_decode_scale.sv
tb/tiled_rgb5a3_checker.sv
tb/tb_tiled_rgb5a3_texel_decode_scale.sv
